// ----- src/fr_pkg.sv -----
// Package for the fraction reducer: command and status words passed between
// the controller and the datapath. No dependencies.
package fr_pkg;

	typedef struct packed {
		logic load;
		logic gcd_step;
		logic g_latch;
		logic div_step;
		logic write_out;
	} cmd_t;

	typedef struct packed {
		logic special;
		logic gcd_done;
		logic div_done;
	} stat_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_GCD  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

endpackage

// ----- src/fr_in_if.sv -----
// Input channel of the fraction reducer: valid/ready handshake with one
// numerator/denominator word. No dependencies.
interface fr_in_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] in_numerator;
	logic signed [W-1:0] in_denominator;

	modport source (output valid, output in_numerator, output in_denominator, input ready);
	modport sink (input valid, input in_numerator, input in_denominator, output ready);
endinterface

// ----- src/fr_out_if.sv -----
// Output channel of the fraction reducer: valid/ready handshake with the
// reduced fraction and a status bit. No dependencies.
interface fr_out_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] out_numerator;
	logic signed [W-1:0] out_denominator;
	logic                status;

	modport source (output valid, output out_numerator, output out_denominator,
		output status, input ready);
	modport sink (input valid, input out_numerator, input out_denominator,
		input status, output ready);
endinterface

// ----- src/fraction_reduce_top.sv -----
// Fraction reducer top level: reduces a signed fraction to lowest terms.
// Binary GCD (data dependent), then restoring division by the GCD, then a result write;
// a zero operand skips the GCD and the division and goes to the write.
// One word in flight; the next is taken in the cycle after the write, and the write
// waits while the previous result is still pending.
// arst_n clears the controller and the output valid; payload is not reset.
module fraction_reduce_top #(
	parameter int VALUE_WIDTH = 32
) (
	input logic       clk,
	input logic       arst_n,
	fr_in_if.sink     in_ch,
	fr_out_if.source  out_ch
);
	import fr_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic [VALUE_WIDTH-1:0] res_num, res_den;
	logic                   res_stat;

	fr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fr_dpath #(.W(VALUE_WIDTH)) u_dpath (
		.clk             (clk),
		.in_numerator    (in_ch.in_numerator),
		.in_denominator  (in_ch.in_denominator),
		.cmd             (cmd),
		.stat            (stat),
		.out_numerator   (res_num),
		.out_denominator (res_den),
		.status          (res_stat)
	);

	assign out_ch.out_numerator   = res_num;
	assign out_ch.out_denominator = res_den;
	assign out_ch.status          = res_stat;

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_out |-> (!out_ch.valid || out_ch.ready))
		else $error("result overwritten while pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input taken while busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status) |->
			(out_ch.out_numerator == '0 && out_ch.out_denominator == '0))
		else $error("error word not zeroed");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.status) |-> (out_ch.out_denominator != '0))
		else $error("zero denominator on good word");
endmodule

// ----- src/fr_dpath.sv -----
// Datapath of the fraction reducer: magnitudes, binary GCD step unit,
// two restoring divider lanes sharing the divisor, and the result register.
// Depends on fr_pkg.
module fr_dpath #(
	parameter int W = 32
) (
	input  logic          clk,
	input  logic [W-1:0]  in_numerator,
	input  logic [W-1:0]  in_denominator,
	input  fr_pkg::cmd_t  cmd,
	output fr_pkg::stat_t stat,
	output logic [W-1:0]  out_numerator,
	output logic [W-1:0]  out_denominator,
	output logic          status
);
	import fr_pkg::*;

	localparam int KW = $clog2(W);
	localparam logic [KW-1:0] LAST = KW'(W - 1);

	logic [W-1:0]  a_q, b_q, g_q;
	logic [W-1:0]  nq_q, dq_q, nr_q, dr_q;
	logic [KW-1:0] k_q, cnt_q;
	logic          nneg_q, dneg_q, zden_q, znum_q;
	logic [W-1:0]  onum_q, oden_q;
	logic          ostat_q;

	logic [W-1:0]  a_mag, b_mag;
	logic [W-1:0]  a_nx, b_nx;
	logic [KW-1:0] k_nx;
	logic [W-1:0]  diff_ab, diff_ba;
	logic [W:0]    nr_sh, dr_sh, g_ext;
	logic          n_bit, d_bit;
	logic [W-1:0]  nr_nx, dr_nx;
	logic [W-1:0]  res_n, res_d;

	assign a_mag = in_numerator[W-1] ? (~in_numerator + W'(1)) : in_numerator;
	assign b_mag = in_denominator[W-1] ? (~in_denominator + W'(1)) : in_denominator;

	assign diff_ab = a_q - b_q;
	assign diff_ba = b_q - a_q;

	// binary GCD: strip twos, subtract smaller odd from larger odd
	always_comb begin
		a_nx = a_q;
		b_nx = b_q;
		k_nx = k_q;
		if (!a_q[0] && !b_q[0]) begin
			a_nx = a_q >> 1;
			b_nx = b_q >> 1;
			k_nx = k_q + KW'(1);
		end else if (!a_q[0]) begin
			a_nx = a_q >> 1;
		end else if (!b_q[0]) begin
			b_nx = b_q >> 1;
		end else if (a_q >= b_q) begin
			a_nx = diff_ab >> 1;
		end else begin
			b_nx = diff_ba >> 1;
		end
	end

	// restoring division, one quotient bit per lane per cycle
	always_comb begin
		g_ext = {1'b0, g_q};
		nr_sh = {nr_q, nq_q[W-1]};
		dr_sh = {dr_q, dq_q[W-1]};
		n_bit = (nr_sh >= g_ext);
		d_bit = (dr_sh >= g_ext);
		nr_nx = n_bit ? W'(nr_sh - g_ext) : nr_sh[W-1:0];
		dr_nx = d_bit ? W'(dr_sh - g_ext) : dr_sh[W-1:0];
	end

	assign res_n = nneg_q ? (~nq_q + W'(1)) : nq_q;
	assign res_d = dneg_q ? (~dq_q + W'(1)) : dq_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q    <= a_mag;
			b_q    <= b_mag;
			nq_q   <= a_mag;
			dq_q   <= b_mag;
			k_q    <= '0;
			nneg_q <= in_numerator[W-1];
			dneg_q <= in_denominator[W-1];
			zden_q <= (in_denominator == '0);
			znum_q <= (in_numerator == '0);
		end else if (cmd.gcd_step) begin
			a_q <= a_nx;
			b_q <= b_nx;
			k_q <= k_nx;
		end
		if (cmd.g_latch) begin
			g_q   <= (a_q | b_q) << k_q;
			nr_q  <= '0;
			dr_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			nr_q  <= nr_nx;
			dr_q  <= dr_nx;
			nq_q  <= {nq_q[W-2:0], n_bit};
			dq_q  <= {dq_q[W-2:0], d_bit};
			cnt_q <= cnt_q + KW'(1);
		end
		if (cmd.write_out) begin
			if (zden_q) begin
				onum_q  <= '0;
				oden_q  <= '0;
				ostat_q <= 1'b1;
			end else if (znum_q) begin
				onum_q  <= '0;
				oden_q  <= W'(1);
				ostat_q <= 1'b0;
			end else begin
				onum_q  <= res_n;
				oden_q  <= res_d;
				ostat_q <= 1'b0;
			end
		end
	end

	assign stat.special  = zden_q | znum_q;
	assign stat.gcd_done = (a_q == '0) | (b_q == '0);
	assign stat.div_done = (cnt_q == LAST);

	assign out_numerator   = onum_q;
	assign out_denominator = oden_q;
	assign status          = ostat_q;
endmodule

// ----- src/fr_ctrl.sv -----
// Controller of the fraction reducer: one-hot state machine sequencing
// load, GCD, division and result write; owns the output valid flag.
// Depends on fr_pkg.
module fr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  fr_pkg::stat_t stat,
	output fr_pkg::cmd_t  cmd
);
	import fr_pkg::*;

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_GCD;
				end
			end
			ST_GCD: begin
				if (stat.special) begin
					state_nx = ST_FIN;
				end else if (stat.gcd_done) begin
					cmd.g_latch = 1'b1;
					state_nx    = ST_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.write_out = 1'b1;
					state_nx      = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.write_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule
